@@ design/mbe_pkg.sv @@
// Shared types and constants of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mbe_pkg;

  // Field and register widths
  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 60;
  localparam int COORD_W    = 64;
  localparam int STEP_W     = 63;
  localparam int ITER_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  // Mapping product: pixel times step, exact
  localparam int PROD_W = PIXEL_BITS + STEP_W;

  // Iteration datapath: |z| components stay within [-2, 2]
  localparam int MAG_W  = FRAC_BITS + 2;
  localparam int HALF_W = (MAG_W + 1) / 2;
  localparam int PP_W   = 2 * HALF_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = COORD_W + FRAC_BITS + 2;
  localparam int NZ_W   = ACC_W - FRAC_BITS;

  // Register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REAL_MIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAG_MIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP = 3'd4;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              inside_res;
  } out_t;

  // Mapped point c, signed fixed point
  typedef struct packed {
    logic [COORD_W-1:0] cr;
    logic [COORD_W-1:0] ci;
  } coord_t;

  typedef struct packed {
    logic [ITER_W-1:0]  max_iter;
    logic [COORD_W-1:0] real_min;
    logic [COORD_W-1:0] imag_min;
    logic [STEP_W-1:0]  real_step;
    logic [STEP_W-1:0]  imag_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_iter:  16'd256,
    real_min:  64'hE000_0000_0000_0000,
    imag_min:  64'hE800_0000_0000_0000,
    real_step: 63'h0002_0000_0000_0000,
    imag_step: 63'h0002_0000_0000_0000
  };

endpackage

@@ design/mbe_front.sv @@
// Front end: accepts pixels and maps them to the saturated point c.
`timescale 1ns / 1ps

module mbe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  mbe_pkg::in_t         in_data,
  input  mbe_pkg::cfg_t        cfg,
  output logic                 q_push,
  input  logic                 q_full,
  output mbe_pkg::coord_t      q_data
);

  localparam int SUM_W = mbe_pkg::PROD_W + 1;
  localparam logic [mbe_pkg::COORD_W-1:0] BIAS = {1'b1, {(mbe_pkg::COORD_W-1){1'b0}}};
  localparam logic [mbe_pkg::COORD_W-1:0] TOP  = {1'b0, {(mbe_pkg::COORD_W-1){1'b1}}};

  logic                        busy_r;
  logic [mbe_pkg::PROD_W-1:0]  prod_re_r;
  logic [mbe_pkg::PROD_W-1:0]  prod_im_r;
  logic                        accept;

  // Add the offset-binary minimum to the product; clamp when it passes the top
  function automatic logic [mbe_pkg::COORD_W-1:0] sat_map(
    input logic [mbe_pkg::COORD_W-1:0] minv,
    input logic [mbe_pkg::PROD_W-1:0]  prod
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(minv ^ BIAS) + SUM_W'(prod);
    if (sum[SUM_W-1:mbe_pkg::COORD_W] != '0) begin
      return TOP;
    end
    return sum[mbe_pkg::COORD_W-1:0] ^ BIAS;
  endfunction

  assign in_full = busy_r;
  assign accept  = in_push & ~busy_r;
  assign q_push  = busy_r & ~q_full;

  assign q_data.cr = sat_map(cfg.real_min, prod_re_r);
  assign q_data.ci = sat_map(cfg.imag_min, prod_im_r);

  // Hold one item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (q_push) begin
      busy_r <= 1'b0;
    end
  end

  // Multiply pixel by step on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_re_r <= mbe_pkg::PROD_W'(in_data.pixel_x) * mbe_pkg::PROD_W'(cfg.real_step);
      prod_im_r <= mbe_pkg::PROD_W'(in_data.pixel_y) * mbe_pkg::PROD_W'(cfg.imag_step);
    end
  end

endmodule

@@ design/mbe_queue.sv @@
// Short queue of mapped points between front and back end.
`timescale 1ns / 1ps

module mbe_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  mbe_pkg::coord_t wr_data,
  input  logic            pop,
  output logic            empty,
  output mbe_pkg::coord_t rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbe_pkg::coord_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/mbe_iter.sv @@
// Back end: iterates z = z^2 + c with a shared 31x31 multiplier and holds the result.
`timescale 1ns / 1ps

module mbe_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  mbe_pkg::coord_t             q_data,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iter,
  output logic                        out_empty,
  input  logic                        out_pop,
  output mbe_pkg::out_t               out_data
);

  localparam int F    = mbe_pkg::FRAC_BITS;
  localparam int H    = mbe_pkg::HALF_W;
  localparam int MW   = mbe_pkg::MAG_W;
  localparam int SQW  = mbe_pkg::SQ_W;
  localparam int AW   = mbe_pkg::ACC_W;
  localparam int NW   = mbe_pkg::NZ_W;
  localparam int CW   = mbe_pkg::COORD_W;

  localparam logic signed [NW-1:0] LIM_POS =
    {{(NW-F-2){1'b0}}, 1'b1, {(F+1){1'b0}}};
  localparam logic signed [NW-1:0] LIM_NEG = -LIM_POS;
  localparam logic [SQW:0] FOUR = (SQW+1)'(1) << (2*F + 2);

  // Three products of four partials each
  localparam logic [3:0] K_LAST = 4'd12;
  localparam logic [1:0] SEL_AA = 2'd0;
  localparam logic [1:0] SEL_BB = 2'd1;
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_HH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_ADD,
    S_RANGE,
    S_MUL,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                    state_r;
  logic                      res_vld_r;
  mbe_pkg::out_t             res_r;
  logic [CW-1:0]             cr_r;
  logic [CW-1:0]             ci_r;
  logic [SQW-1:0]            sr_r;
  logic [SQW-1:0]            si_r;
  logic [SQW-1:0]            cx_r;
  logic                      cx_neg_r;
  logic [mbe_pkg::ITER_W-1:0] n_r;
  logic [AW-1:0]             acc_re_r;
  logic [AW-1:0]             acc_im_r;
  logic [MW-1:0]             ma_r;
  logic [MW-1:0]             mb_r;
  logic [mbe_pkg::PP_W-1:0]  pp_r;
  logic [SQW-1:0]            sq_acc_r;
  logic [3:0]                k_r;

  logic [AW-1:0]             crw;
  logic [AW-1:0]             ciw;
  logic [AW-1:0]             cx2;
  logic [AW-1:0]             re_sum;
  logic [AW-1:0]             im_sum;
  logic signed [NW-1:0]      nr;
  logic signed [NW-1:0]      ni;
  logic [NW-1:0]             nr_abs;
  logic [NW-1:0]             ni_abs;
  logic                      out_range;
  logic [1:0]                sel;
  logic [1:0]                part;
  logic [MW-1:0]             opx;
  logic [MW-1:0]             opy;
  logic [H-1:0]              px;
  logic [H-1:0]              py;
  logic [3:0]                km1;
  logic [SQW-1:0]            pp_shift;
  logic [SQW-1:0]            acc_nxt;
  logic [SQW:0]              mag;
  logic                      res_take;
  logic                      res_load;

  assign q_pop     = (state_r == S_IDLE) & ~q_empty;
  assign out_empty = ~res_vld_r;
  assign out_data  = res_r;
  assign res_take  = ~res_vld_r | out_pop;
  assign res_load  = (state_r == S_DONE) & res_take;

  // Next components before rounding: zr^2 - zi^2 + cr and 2 zr zi + ci
  always_comb begin
    crw    = {{(AW-CW-F){cr_r[CW-1]}}, cr_r, {F{1'b0}}};
    ciw    = {{(AW-CW-F){ci_r[CW-1]}}, ci_r, {F{1'b0}}};
    cx2    = AW'({cx_r, 1'b0});
    re_sum = crw + AW'(sr_r) - AW'(si_r);
    im_sum = ciw + (cx_neg_r ? -cx2 : cx2);
  end

  // Round toward minus infinity, range test and magnitudes
  always_comb begin
    nr        = $signed(acc_re_r[AW-1:F]);
    ni        = $signed(acc_im_r[AW-1:F]);
    nr_abs    = nr[NW-1] ? -nr : nr;
    ni_abs    = ni[NW-1] ? -ni : ni;
    out_range = (nr > LIM_POS) || (nr < LIM_NEG) || (ni > LIM_POS) || (ni < LIM_NEG);
  end

  // Pick the partial product issued this cycle
  always_comb begin
    sel  = k_r[3:2];
    part = k_r[1:0];
    opx  = (sel == SEL_BB) ? mb_r : ma_r;
    opy  = (sel == SEL_AA) ? ma_r : mb_r;
    px   = part[1] ? H'(opx[MW-1:H]) : opx[H-1:0];
    py   = part[0] ? H'(opy[MW-1:H]) : opy[H-1:0];
  end

  // Accumulate the partial issued last cycle
  always_comb begin
    km1 = k_r - 4'd1;
    unique case (km1[1:0])
      PART_LL: pp_shift = SQW'(pp_r);
      PART_HH: pp_shift = SQW'(pp_r) << (2*H);
      default: pp_shift = SQW'(pp_r) << H;
    endcase
    acc_nxt = ((km1[1:0] == PART_LL) ? '0 : sq_acc_r) + pp_shift;
    mag     = (SQW+1)'(sr_r) + (SQW+1)'(si_r);
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (out_pop && res_vld_r) begin
        res_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cr_r     <= q_data.cr;
            ci_r     <= q_data.ci;
            sr_r     <= '0;
            si_r     <= '0;
            cx_r     <= '0;
            cx_neg_r <= 1'b0;
            n_r      <= '0;
            state_r  <= S_LOOP;
          end
        end
        S_LOOP: begin
          state_r <= (n_r >= max_iter) ? S_DONE : S_ADD;
        end
        S_ADD: begin
          acc_re_r <= re_sum;
          acc_im_r <= im_sum;
          state_r  <= S_RANGE;
        end
        S_RANGE: begin
          ma_r     <= nr_abs[MW-1:0];
          mb_r     <= ni_abs[MW-1:0];
          cx_neg_r <= nr[NW-1] ^ ni[NW-1];
          k_r      <= '0;
          state_r  <= out_range ? S_DONE : S_MUL;
        end
        S_MUL: begin
          if (k_r != K_LAST) begin
            pp_r <= px * py;
          end
          if (k_r != 4'd0) begin
            sq_acc_r <= acc_nxt;
            if (km1[1:0] == PART_HH) begin
              unique case (km1[3:2])
                SEL_AA:  sr_r <= acc_nxt;
                SEL_BB:  si_r <= acc_nxt;
                default: cx_r <= acc_nxt;
              endcase
            end
          end
          k_r <= k_r + 4'd1;
          if (k_r == K_LAST) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mag > FOUR) begin
            state_r <= S_DONE;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_LOOP;
          end
        end
        S_DONE: begin
          if (res_take) begin
            res_r.iterations <= n_r;
            res_r.inside_res <= (n_r >= max_iter);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/mandelbrot_escape_time_top.sv @@
// Top level of the Mandelbrot escape-time block: registers, front end, queue, back end.
//
//   channel   ports                          payload
//   input     in_push / in_full / in_data    pixel_x, pixel_y
//   result    out_pop / out_empty / out_data iterations, inside_res
//   config    cfg_we / cfg_addr / cfg_wdata  max_iter, real_min, imag_min, steps
//
// The front end registers pixel times step, maps c from that product and passes c
// through the queue. Each back-end iteration runs S_LOOP, S_ADD, S_RANGE, the multiply
// phase S_MUL (which issues twelve 31x31 partials for zr^2, zi^2 and zr*zi) and S_CHECK;
// an item ends at the limit n, or early when step n+1 escapes by range or by |z|^2.
// Reset is synchronous; registers return to their default view of the set.
// A full result register stalls only the back end; the front keeps filling the queue.
`timescale 1ns / 1ps

module mandelbrot_escape_time_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  mbe_pkg::in_t                       in_data,
  output logic                               out_empty,
  input  logic                               out_pop,
  output mbe_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  mbe_pkg::cfg_t   cfg_r;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  mbe_pkg::coord_t q_wr_data;
  mbe_pkg::coord_t q_rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mbe_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mbe_pkg::REG_MAX_ITER:  cfg_r.max_iter  <= cfg_wdata[mbe_pkg::ITER_W-1:0];
        mbe_pkg::REG_REAL_MIN:  cfg_r.real_min  <= cfg_wdata[mbe_pkg::COORD_W-1:0];
        mbe_pkg::REG_IMAG_MIN:  cfg_r.imag_min  <= cfg_wdata[mbe_pkg::COORD_W-1:0];
        mbe_pkg::REG_REAL_STEP: cfg_r.real_step <= cfg_wdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_IMAG_STEP: cfg_r.imag_step <= cfg_wdata[mbe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wr_data)
  );

  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  mbe_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rd_data),
    .max_iter  (cfg_r.max_iter),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_mandelbrot_escape_time_top.sv @@
// Self-checking testbench for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_top;
  import mbe_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_PCT     = 9;
  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_ITEMS = 1150;
  localparam int TAIL_CYCLES  = 64;
  localparam int SETTLE       = 4;
  // Abort bound, well above the slowest possible run
  localparam int LIMIT_CYCLES = 10_000_000;

  // Window around the set used by most random settings: real from -2.25, imag from -1.5
  localparam logic [COORD_W-1:0] RE_LO   = 64'hDC00_0000_0000_0000;
  localparam logic [COORD_W-1:0] RE_SPAN = 64'h2C00_0000_0000_0000;
  localparam logic [COORD_W-1:0] IM_LO   = 64'hE800_0000_0000_0000;
  localparam logic [COORD_W-1:0] IM_SPAN = 64'h1800_0000_0000_0000;

  typedef enum logic [1:0] {SPREAD_WINDOW, SPREAD_ZOOM, SPREAD_WILD} spread_t;

  // Expected escape counts, kept in the order the pixels went in
  class escape_scoreboard;
    cfg_t        regs;
    out_t        expected_counts[$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned n_inside;
    int unsigned deepest;

    function new();
      regs = CFG_RESET;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MAX_ITER:  regs.max_iter  = v[ITER_W-1:0];
        REG_REAL_MIN:  regs.real_min  = v;
        REG_IMAG_MIN:  regs.imag_min  = v;
        REG_REAL_STEP: regs.real_step = v[STEP_W-1:0];
        REG_IMAG_STEP: regs.imag_step = v[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // base + pix * step, exact, clipped to the largest positive coordinate
    function logic [COORD_W-1:0] map_axis(logic [COORD_W-1:0] base, logic [STEP_W-1:0] step,
                                          logic [PIXEL_BITS-1:0] pix);
      logic [79:0] prod;
      logic [79:0] sum;
      prod = {68'b0, pix} * {17'b0, step};
      sum  = {{16{base[COORD_W-1]}}, base} + prod;
      if (!sum[79] && (|sum[78:63]))
        return 64'h7FFF_FFFF_FFFF_FFFF;
      return sum[COORD_W-1:0];
    endfunction

    // Iterate z = z^2 + c from zero until |z|^2 > 4 or the limit is hit
    function out_t escape_count(in_t px);
      logic signed [COORD_W-1:0] cr, ci, zr, zi;
      logic signed [127:0] ar, ai, cw_r, cw_i, nr, ni, mag, lim, four;
      int unsigned n;
      bit done;
      out_t r;
      lim  = 128'sd1 <<< (FRAC_BITS + 1);
      four = 128'sd1 <<< (2 * FRAC_BITS + 2);
      cr = map_axis(regs.real_min, regs.real_step, px.pixel_x);
      ci = map_axis(regs.imag_min, regs.imag_step, px.pixel_y);
      cw_r = cr;
      cw_i = ci;
      cw_r = cw_r <<< FRAC_BITS;
      cw_i = cw_i <<< FRAC_BITS;
      zr = '0;
      zi = '0;
      n = 0;
      done = 1'b0;
      while (!done && n < regs.max_iter) begin
        ar = zr;
        ai = zi;
        nr = (ar * ar - ai * ai + cw_r) >>> FRAC_BITS;
        ni = (((ar * ai) <<< 1) + cw_i) >>> FRAC_BITS;
        if (nr > lim || nr < -lim || ni > lim || ni < -lim) begin
          done = 1'b1;
        end else begin
          mag = nr * nr + ni * ni;
          if (mag > four) begin
            done = 1'b1;
          end else begin
            zr = nr[COORD_W-1:0];
            zi = ni[COORD_W-1:0];
            n++;
          end
        end
      end
      r.iterations = n[ITER_W-1:0];
      r.inside_res = (n >= regs.max_iter);
      return r;
    endfunction

    function void note_pixel(in_t px);
      expected_counts.push_back(escape_count(px));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_counts.size() == 0) begin
        n_fail++;
        $display("%0t: result with nothing expected: iterations %0d inside %0b",
                 $time, got.iterations, got.inside_res);
        return;
      end
      want = expected_counts.pop_front();
      n_checked++;
      if (got.inside_res) n_inside++;
      if (got.iterations > deepest) deepest = got.iterations;
      if (got.iterations !== want.iterations) begin
        n_fail++;
        $display("%0t: iterations expected %0d, got %0d", $time, want.iterations,
                 got.iterations);
      end
      if (got.inside_res !== want.inside_res) begin
        n_fail++;
        $display("%0t: inside_res expected %0b, got %0b", $time, want.inside_res,
                 got.inside_res);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t  in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  escape_scoreboard sb;
  bit hold_req = 1'b0;
  bit calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned full_waits = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings = 0;

  mandelbrot_escape_time_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d results outstanding", $time, sb.expected_counts.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Pop results with random stalls; hold off for a long stretch on request
  initial begin : result_drain
    int hold_left;
    hold_left = 0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_data);
    end
  end

  // Offer one item at a falling edge; return at the falling edge after it is taken
  task automatic push_pixel(input in_t px);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_full) begin
      full_waits++;
      @(posedge clk);
    end
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic push_xy(input int x, input int y);
    in_t px;
    px.pixel_x = x[PIXEL_BITS-1:0];
    px.pixel_y = y[PIXEL_BITS-1:0];
    push_pixel(px);
  endtask

  // Hold a register write for one cycle; leave the enable up for a following write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  // Wait until every expected result has been popped and the block has settled
  task automatic wait_drain();
    @(negedge clk);
    while (sb.expected_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all five registers, with junk in the bits above the limit and step widths
  task automatic apply_setting(input cfg_t s);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    wait_drain();
    write_reg(REG_MAX_ITER, {junk[63:ITER_W], s.max_iter});
    write_reg(REG_REAL_MIN, s.real_min);
    write_reg(REG_IMAG_MIN, s.imag_min);
    write_reg(REG_REAL_STEP, {junk[0], s.real_step});
    write_reg(REG_IMAG_STEP, {junk[1], s.imag_step});
    cfg_we <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  function automatic cfg_t random_setting(spread_t spread);
    cfg_t s;
    logic [63:0] r1, r2, stp;
    int pick;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    // Keep the limit small most of the time, since every step runs the full multiply sequence
    if (pick == 0) s.max_iter = '0;
    else if (pick == 1) s.max_iter = ITER_W'($urandom_range(60, 120));
    else s.max_iter = ITER_W'($urandom_range(1, 30));
    case (spread)
      SPREAD_WILD: begin
        s.real_min = r1;
        s.imag_min = r2;
        stp = {$urandom, $urandom} >> $urandom_range(0, 62);
        s.real_step = stp[STEP_W-1:0];
        stp = {$urandom, $urandom} >> $urandom_range(0, 62);
        s.imag_step = stp[STEP_W-1:0];
      end
      SPREAD_ZOOM: begin
        s.real_min = RE_LO + (r1 % RE_SPAN);
        s.imag_min = IM_LO + (r2 % IM_SPAN);
        stp = {$urandom, $urandom} >> $urandom_range(30, 55);
        s.real_step = stp[STEP_W-1:0];
        stp = {$urandom, $urandom} >> $urandom_range(30, 55);
        s.imag_step = stp[STEP_W-1:0];
      end
      default: begin
        s.real_min = RE_LO + (r1 % RE_SPAN);
        s.imag_min = IM_LO + (r2 % IM_SPAN);
        stp = {$urandom, $urandom} >> $urandom_range(13, 20);
        s.real_step = stp[STEP_W-1:0];
        stp = {$urandom, $urandom} >> $urandom_range(13, 20);
        s.imag_step = stp[STEP_W-1:0];
      end
    endcase
    return s;
  endfunction

  initial begin : stimulus
    cfg_t s;
    int n_items;
    int phase;
    int idx;
    int pick;
    int unsigned rand_sent;
    spread_t spread;

    sb = new();
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: corners, points on the real axis inside the set,
    // c = -2 where |z|^2 sits exactly at 4, c = -0.75 where the cardioid meets the bulb and just past it
    push_xy(0, 0);
    push_xy(4095, 4095);
    push_xy(0, 3072);
    push_xy(2048, 3072);
    push_xy(2560, 3072);
    push_xy(2561, 3072);
    push_xy(1024, 768);
    in_push <= 1'b0;

    // Zero limit; writes to unused register indexes must change nothing
    s = CFG_RESET;
    s.max_iter = '0;
    apply_setting(s);
    for (idx = int'(REG_IMAG_STEP) + 1; idx < (1 << CFG_ADDR_W); idx++)
      write_reg(idx[CFG_ADDR_W-1:0], {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(negedge clk);
    push_xy(0, 0);
    push_xy(4095, 4095);
    in_push <= 1'b0;

    // Largest limit with extreme registers; mapped real parts clip to the top
    s.max_iter  = '1;
    s.real_min  = 64'h7FFF_FFFF_FFFF_FFFF;
    s.imag_min  = 64'h8000_0000_0000_0000;
    s.real_step = '1;
    s.imag_step = '1;
    apply_setting(s);
    push_xy(0, 0);
    push_xy(4095, 4095);
    push_xy(4095, 0);
    in_push <= 1'b0;

    // Limit of one
    s = CFG_RESET;
    s.max_iter = 16'd1;
    apply_setting(s);
    push_xy(0, 0);
    push_xy(2048, 3072);
    in_push <= 1'b0;

    // Real part one LSB below -2, then exactly -2, then one above
    s.max_iter  = 16'd40;
    s.real_min  = 64'hDFFF_FFFF_FFFF_FFFF;
    s.real_step = 63'd1;
    s.imag_min  = '0;
    s.imag_step = 63'h0800_0000_0000_0000;
    apply_setting(s);
    push_xy(0, 0);
    push_xy(1, 0);
    push_xy(2, 0);
    push_xy(1, 1);
    in_push <= 1'b0;

    // Unit steps: c = 2i and c = 2 sit on the escape circle, far corner clips
    s.real_min  = '0;
    s.imag_min  = '0;
    s.real_step = 63'h1000_0000_0000_0000;
    s.imag_step = 63'h1000_0000_0000_0000;
    apply_setting(s);
    push_xy(0, 2);
    push_xy(2, 0);
    push_xy(0, 0);
    push_xy(1, 1);
    push_xy(4095, 4095);
    in_push <= 1'b0;

    // Random settings, each followed by a batch of random pixels
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) spread = SPREAD_WILD;
      else if (pick < 3) spread = SPREAD_ZOOM;
      else spread = SPREAD_WINDOW;
      s = random_setting(spread);
      n_items = (s.max_iter > 30) ? 8 : $urandom_range(20, 60);
      if (phase == 0) begin
        // Short items with the receiver held off, so the block backs up
        s = CFG_RESET;
        s.max_iter = 16'd3;
        n_items = 48;
      end
      apply_setting(s);
      if (phase == 0) hold_req = 1'b1;
      calm = (phase == 2);
      repeat (n_items) begin
        push_xy($urandom_range(0, 4095), $urandom_range(0, 4095));
        rand_sent++;
      end
      in_push <= 1'b0;
      calm = 1'b0;
      phase++;
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d pixels through %0d register settings; %0d results checked, %0d inside",
             pixels_sent, settings + 1, sb.n_checked, sb.n_inside);
    $display("Deepest count %0d; input held off by a full block for %0d cycles",
             sb.deepest, full_waits);
    if (sb.n_fail == 0 && sb.expected_counts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mbe_pkg.sv
design/mbe_front.sv
design/mbe_queue.sv
design/mbe_iter.sv
design/mandelbrot_escape_time_top.sv
test/tb_mandelbrot_escape_time_top.sv
